FILE: rtl/core/lgs_pkg.sv
// ----------------------------------------------------------------------------
// Life generation stencil package
// Shared constants, register indexes, the per-cell tag type and the B3/S23
// rule helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

  localparam int COORD_W       = 10;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_IDX_W     = 2;
  // Comparison width for positions and counts; holds counts up to 8191.
  localparam int CMP_W         = 13;
  localparam int DEFAULT_COUNT = 100;
  localparam int MIN_COUNT     = 3;

  // Default grid limits for the top level.
  localparam int DEFAULT_MAX_ROWS    = 1024;
  localparam int DEFAULT_MAX_COLUMNS = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  // Per-cell information worked out when the cell is taken in.
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
  } lgs_tag_t;

  // Limits a written count to the range from MIN_COUNT to max_count.
  function automatic logic [CMP_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v,
                                                   input logic [CMP_W-1:0] max_count);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    priority if (w < CMP_W'(MIN_COUNT)) begin
      return CMP_W'(MIN_COUNT);
    end else if (w > max_count) begin
      return max_count;
    end else begin
      return w;
    end
  endfunction

  // Next state of the window center; bit 4 is the center cell.
  function automatic logic life_rule(input logic [8:0] w);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        n = n + 4'(w[k]);
      end
    end
    return w[4] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lgs_cell_if.sv
// ----------------------------------------------------------------------------
// Cell input channel
// Valid/ready channel that carries one grid cell in raster order.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lgs_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one interior cell of the next generation.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_result_if
  import lgs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               next_alive;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_column;
  logic               last_of_frame;

  modport source (output valid, output next_alive, output out_row, output out_column,
                  output last_of_frame, input ready);
  modport sink (input valid, input next_alive, input out_row, input out_column,
                input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lgs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_cfg_if
  import lgs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lgs_scan.sv
// ----------------------------------------------------------------------------
// Raster scan counters
// Holds the grid size registers and the raster position of the next cell,
// and derives the tag of the cell at that position.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_scan
  import lgs_pkg::*;
#(
  parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
  parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  advance,
  output logic                       restart,
  output logic [$clog2(MAX_COLUMNS)-1:0] column,
  output lgs_tag_t                   tag
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);

  logic [RW-1:0]    row_pos;
  logic [CW-1:0]    col_pos;
  logic [RCW-1:0]   row_count;
  logic [CCW-1:0]   column_count;
  logic [CMP_W-1:0] r_ext, c_ext, r_inc, c_inc;
  logic             row_wrap, col_wrap;

  assign r_ext = CMP_W'(row_pos);
  assign c_ext = CMP_W'(col_pos);
  assign r_inc = r_ext + CMP_W'(1);
  assign c_inc = c_ext + CMP_W'(1);

  assign row_wrap = (r_inc >= CMP_W'(row_count));
  assign col_wrap = (c_inc >= CMP_W'(column_count));

  assign restart = cfg_write && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT);
  assign column  = col_pos;

  always_comb begin
    tag.emit   = (r_ext >= CMP_W'(2)) && (c_ext >= CMP_W'(2));
    tag.last   = (r_inc == CMP_W'(row_count)) && (c_inc == CMP_W'(column_count));
    tag.row    = COORD_W'(r_ext - CMP_W'(1));
    tag.column = COORD_W'(c_ext - CMP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos      <= '0;
      col_pos      <= '0;
      row_count    <= RCW'(clamp_count(CFG_DATA_W'(DEFAULT_COUNT), CMP_W'(MAX_ROWS)));
      column_count <= CCW'(clamp_count(CFG_DATA_W'(DEFAULT_COUNT), CMP_W'(MAX_COLUMNS)));
    end else if (restart) begin
      row_pos <= '0;
      col_pos <= '0;
      if (cfg_index == REG_ROW_COUNT) begin
        row_count <= RCW'(clamp_count(cfg_data, CMP_W'(MAX_ROWS)));
      end else begin
        column_count <= CCW'(clamp_count(cfg_data, CMP_W'(MAX_COLUMNS)));
      end
    end else if (advance) begin
      if (col_wrap) begin
        col_pos <= '0;
        row_pos <= row_wrap ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lgs_line_mem.sv
// ----------------------------------------------------------------------------
// Line store memory
// One entry per column; bit 1 is the cell two rows up, bit 0 one row up.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_line_mem
  import lgs_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_COLUMNS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [1:0]               wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [1:0]                    rdata
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lgs_window.sv
// ----------------------------------------------------------------------------
// Window stage and result register
// Holds the cell whose line store read is in flight, writes the line store
// back, shifts the 3x3 window and registers the next-generation result.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_window
  import lgs_pkg::*;
#(
  parameter int CW = $clog2(DEFAULT_MAX_COLUMNS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               restart,
  input  wire logic               in_valid,
  input  wire logic               in_cell,
  input  wire logic [CW-1:0]      in_column,
  input  wire lgs_tag_t           in_tag,
  output logic                    in_ready,
  output logic                    busy,
  input  wire logic [1:0]         rd_data,
  output logic                    wr_en,
  output logic [CW-1:0]           wr_addr,
  output logic [1:0]              wr_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_alive,
  output logic [COORD_W-1:0]      out_row,
  output logic [COORD_W-1:0]      out_column,
  output logic                    out_last
);

  logic          a_valid;
  logic          a_cell;
  logic [CW-1:0] a_column;
  lgs_tag_t      a_tag;
  logic [8:0]    window;
  logic [8:0]    window_next;
  logic          o_free;
  logic          a_adv;
  logic          accept;

  // The stage moves on unless it has a result and the result register is full.
  assign o_free   = !out_valid || out_ready;
  assign a_adv    = a_valid && (!a_tag.emit || o_free);
  assign in_ready = !a_valid || a_adv;
  assign accept   = in_valid && in_ready;
  assign busy     = a_valid;

  // Newest column enters at the bottom bits: top, middle, then current row.
  assign window_next = {window[5:0], rd_data[1], rd_data[0], a_cell};

  assign wr_en   = a_adv;
  assign wr_addr = a_column;
  assign wr_data = {rd_data[0], a_cell};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      window    <= '0;
    end else begin
      if (restart) begin
        window <= '0;
      end else if (a_adv) begin
        window <= window_next;
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv && a_tag.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cell   <= in_cell;
      a_column <= in_column;
      a_tag    <= in_tag;
    end
    if (a_adv && a_tag.emit) begin
      out_alive  <= life_rule(window_next);
      out_row    <= a_tag.row;
      out_column <= a_tag.column;
      out_last   <= a_tag.last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/life_generation_stencil_top.sv
// ----------------------------------------------------------------------------
// Life generation stencil, top level
// Streams one generation of the B3/S23 rule over a grid in raster order.
// ----------------------------------------------------------------------------
// The current grid enters on the cells channel, one cell per transfer, row by
// row and left to right within a row. Each interior cell of the grid comes
// out on the results channel with its next state, its row and column, and a
// flag on the last interior cell of the frame. Border cells are used as
// neighbors only; a consumer treats them as dead.
// The grid size is set through the cfg channel: index 0 is the row count,
// index 1 the column count, each limited to the range from 3 to the maximum.
// A write to either register restarts the frame at cell (0,0). Writes are
// taken in any cycle and should arrive while the block is idle.
// One cell is taken per clock while the window stage can move on. A cell
// waits in the window stage while its column is read from the line store,
// which is written back as the cell leaves; the result of the cell that
// completes a window (one row and one column after the reported cell) goes
// to the result register as that cell leaves. When the receiver stalls, the
// result register holds; border cells still pass the window stage, but the
// next interior cell waits there and input is held off until the result is taken.
// Reset clears the positions, the window and the sizes (100 by 100, or the
// maximum if smaller). The line store is not cleared: every entry that feeds
// a result is written in the frame before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_stencil_top
  import lgs_pkg::*;
#(
  parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
  parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS
) (
  input wire logic     clk,
  input wire logic     rst,
  lgs_cell_if.sink     cells,
  lgs_cfg_if.sink      cfg,
  lgs_result_if.source results
);

  localparam int CW = $clog2(MAX_COLUMNS);

  logic          restart;
  logic [CW-1:0] scan_column;
  lgs_tag_t      scan_tag;
  logic          in_ready;
  logic          accept;
  logic          stage_busy;
  logic [1:0]    rd_data;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [1:0]    wr_data;

  // Configuration is always taken.
  assign cfg.ready   = 1'b1;
  assign cells.ready = in_ready;
  assign accept      = cells.valid && in_ready;

  lgs_scan #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .advance   (accept),
    .restart   (restart),
    .column    (scan_column),
    .tag       (scan_tag)
  );

  // The read for a cell is issued at its transfer; the write-back of the
  // previous cell goes to a different column in the same cycle.
  lgs_line_mem #(
    .DEPTH (MAX_COLUMNS)
  ) u_line_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (scan_column),
    .rdata (rd_data)
  );

  lgs_window #(
    .CW (CW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .in_valid   (cells.valid),
    .in_cell    (cells.cell_alive),
    .in_column  (scan_column),
    .in_tag     (scan_tag),
    .in_ready   (in_ready),
    .busy       (stage_busy),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_alive  (results.next_alive),
    .out_row    (results.out_row),
    .out_column (results.out_column),
    .out_last   (results.last_of_frame)
  );

  // An empty result register never holds off input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> cells.ready)
    else $error("input held off with an empty result register");

  // A result only appears after a cell was in the window stage.
  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(stage_busy))
    else $error("result appeared without a cell in the window stage");

  // Reported cells are interior, so neither coordinate is zero.
  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.out_row != '0 && results.out_column != '0))
    else $error("border cell reported");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life generation stencil testbench
// Streams grids through the B3/S23 stencil and checks every interior result
// against a cycle-free model of the line stores and the 3x3 window.
// ----------------------------------------------------------------------------
// Each transfer on the cells channel goes into a scoreboard. The scoreboard
// keeps its own copy of the line stores, the window, the raster position and
// the grid size, and queues the result that the cell completes. Each transfer
// on the results channel is compared field by field with the oldest queued
// result. Grid sizes are written through the cfg channel only after all
// queued results have arrived and the pipeline has had time to empty.
// ----------------------------------------------------------------------------

module tb;
  import lgs_pkg::*;

  localparam int MAX_ROWS      = DEFAULT_MAX_ROWS;
  localparam int MAX_COLUMNS   = DEFAULT_MAX_COLUMNS;
  // A cell's result leaves through the window stage and the result register; the
  // settle wait also lets any cell that makes no result leave the window stage.
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 64;
  localparam int RANDOM_CELLS  = 400;
  localparam int PHASE_CELLS   = 150;
  localparam int WIDE_COLUMNS  = 200;

  // Indexes that select no register; a write to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic               alive;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               last;
  } cell_result_t;

  // Tracks the next generation that the stencil should produce.
  class life_scoreboard;
    bit           upper_row[MAX_COLUMNS];
    bit           middle_row[MAX_COLUMNS];
    logic [8:0]   window;
    int unsigned  row_pos;
    int unsigned  col_pos;
    int unsigned  rows;
    int unsigned  cols;
    cell_result_t expected[$];
    int           errors;

    function new();
      window  = '0;
      row_pos = 0;
      col_pos = 0;
      rows    = bound_count(11'(DEFAULT_COUNT), MAX_ROWS);
      cols    = bound_count(11'(DEFAULT_COUNT), MAX_COLUMNS);
      errors  = 0;
    endfunction

    function int unsigned bound_count(logic [CFG_DATA_W-1:0] v, int unsigned top);
      int unsigned n;
      n = v;
      if (n < MIN_COUNT) return MIN_COUNT;
      if (n > top) return top;
      return n;
    endfunction

    // A write to a real register restarts the frame at cell (0,0).
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      if (idx == REG_ROW_COUNT || idx == REG_COLUMN_COUNT) begin
        if (idx == REG_ROW_COUNT) begin
          rows = bound_count(v, MAX_ROWS);
        end else begin
          cols = bound_count(v, MAX_COLUMNS);
        end
        window  = '0;
        row_pos = 0;
        col_pos = 0;
      end
    endfunction

    function void note_cell(logic alive);
      logic         above2;
      logic         above1;
      int unsigned  n;
      cell_result_t r;
      above2 = upper_row[col_pos];
      above1 = middle_row[col_pos];
      upper_row[col_pos]  = above1;
      middle_row[col_pos] = alive;
      window = {window[5:0], above2, above1, alive};
      if (row_pos >= 2 && col_pos >= 2) begin
        n        = $countones(window) - window[4];
        r.alive  = window[4] ? (n == 2 || n == 3) : (n == 3);
        r.row    = COORD_W'(row_pos - 1);
        r.column = COORD_W'(col_pos - 1);
        r.last   = (row_pos + 1 == rows) && (col_pos + 1 == cols);
        expected.push_back(r);
      end
      if (col_pos + 1 >= cols) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    task report(string msg);
      $display("[%0t] cell result error: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(cell_result_t got);
      cell_result_t want;
      if (expected.size() == 0) begin
        report($sformatf("result at (%0d,%0d) with none expected", got.row, got.column));
      end else begin
        want = expected.pop_front();
        if (got !== want) begin
          report($sformatf("got alive %0b last %0b at (%0d,%0d), expected alive %0b last %0b at (%0d,%0d)",
                           got.alive, got.last, got.row, got.column,
                           want.alive, want.last, want.row, want.column));
        end
      end
    endtask

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lgs_cell_if   cells_if();
  lgs_cfg_if    cfg_if();
  lgs_result_if results_if();

  life_generation_stencil_top #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cells   (cells_if),
    .cfg     (cfg_if),
    .results (results_if)
  );

  life_scoreboard sb;

  // Idle controls. send_idle and recv_idle are chosen per phase so that some
  // stretches run with no gaps at all; no_idle turns all gaps off for the
  // closing part of the run.
  bit send_idle;
  bit recv_idle;
  bit no_idle;
  int long_hold_asked;
  int cell_items;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the run hangs; this is far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // Every transfer is taken at the rising edge. A result always belongs to a
  // cell taken earlier that has since passed the window stage, so the order of
  // the three checks within one edge does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        sb.check_result('{alive: results_if.next_alive, row: results_if.out_row,
                          column: results_if.out_column, last: results_if.last_of_frame});
      end
      if (cells_if.valid && cells_if.ready) begin
        sb.note_cell(cells_if.cell_alive);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.index, cfg_if.data);
      end
    end
  end

  // Result receiver. Short stalls come in bursts of random length. A
  // long hold, when asked for, keeps ready low long enough for the result
  // register and the window stage to fill and for the block to stall the
  // cells channel.
  int hold_left = 0;
  int stall_left = 0;
  int long_hold_done = 0;

  always @(negedge clk) begin
    if (long_hold_done != long_hold_asked) begin
      long_hold_done = long_hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      results_if.ready <= 1'b0;
    end else if (recv_idle && !no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  // Offers one cell, sometimes after a gap, and waits for its transfer.
  // Valid stays high from one cell to the next when there is no gap.
  task automatic send_cell(input logic alive);
    int gap;
    gap = 0;
    if (send_idle && !no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
    end
    repeat (gap) begin
      @(negedge clk);
      cells_if.valid <= 1'b0;
    end
    @(negedge clk);
    cells_if.valid      <= 1'b1;
    cells_if.cell_alive <= alive;
    do @(posedge clk); while (!cells_if.ready);
    cell_items++;
  endtask

  // density is the chance, in percent, that a cell is alive.
  task automatic stream_cells(input int count, input int density);
    for (int k = 0; k < count; k++) begin
      send_cell(logic'($urandom_range(0, 99) < density));
    end
  endtask

  // Sends one 3x3 grid, top left cell first.
  task automatic send_grid3(input logic [8:0] grid);
    for (int k = 8; k >= 0; k--) begin
      send_cell(grid[k]);
    end
  endtask

  // Stops the cells channel and waits until the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    cells_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Grid dimension for a random phase: mostly tiny, now and then larger.
  function automatic int pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) return $urandom_range(3, 8);
    if (sel < 19) return $urandom_range(9, 24);
    return $urandom_range(25, 48);
  endfunction

  initial begin
    int rows_now;
    int cols_now;
    int frame;
    int count;
    int density;
    int sel;
    int loop_start;
    bit first_phase;

    sb = new();
    rst                 = 1'b1;
    cells_if.valid      = 1'b0;
    cells_if.cell_alive = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_ROW_COUNT;
    cfg_if.data         = '0;
    results_if.ready    = 1'b0;
    send_idle           = 1'b1;
    recv_idle           = 1'b1;
    no_idle             = 1'b0;
    long_hold_asked     = 0;
    cell_items          = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The reset size is 100 by 100; results start once the third row is
    // reached, so a little over two rows checks the reset values.
    stream_cells(230, 50);
    settle();

    // Smallest grid, written with counts below the minimum. A live center
    // with two neighbors survives, a dead center with three is born, and a
    // crowded center dies. The frames follow each other with no break.
    write_reg(REG_ROW_COUNT, 11'd0);
    write_reg(REG_COLUMN_COUNT, 11'd2);
    send_grid3(9'b100_010_001);
    send_grid3(9'b111_000_000);
    send_grid3(9'b111_111_111);
    // Part of a frame, then writes to indexes that hold no register: the
    // frame must carry on where it stopped.
    send_cell(1'b1);
    send_cell(1'b1);
    settle();
    write_reg(REG_SPARE, 11'h7FF);
    write_reg(REG_UNUSED, 11'h2AA);
    send_cell(1'b0);
    send_cell(1'b1);
    send_cell(1'b1);
    settle();

    // Wide grid, three rows: the last result sits in column 198.
    write_reg(REG_ROW_COUNT, 11'd1);
    write_reg(REG_COLUMN_COUNT, 11'(WIDE_COLUMNS));
    stream_cells(3 * WIDE_COLUMNS, 40);
    settle();

    // Tallest grid, written above the maximum; only its first rows run.
    write_reg(REG_ROW_COUNT, 11'd2047);
    write_reg(REG_COLUMN_COUNT, 11'd3);
    stream_cells(300, 50);
    settle();
    rows_now = MAX_ROWS;
    cols_now = 3;

    // Random grids of random sizes and densities. Most phases restart with
    // new sizes; some write one size only, and some carry on in the frame
    // left by the previous phase.
    loop_start  = cell_items;
    first_phase = 1'b1;
    while (cell_items - loop_start < RANDOM_CELLS) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: density = 10;
        1: density = 30;
        2: density = 50;
        default: density = 75;
      endcase
      sel = first_phase ? 3 : $urandom_range(0, 9);
      if (sel == 0 || sel >= 3) begin
        rows_now = pick_size();
        write_reg(REG_ROW_COUNT, (rows_now == 3 && $urandom_range(0, 1) == 1) ?
                  11'($urandom_range(0, 2)) : 11'(rows_now));
      end
      if (sel == 1 || sel >= 3) begin
        cols_now = pick_size();
        write_reg(REG_COLUMN_COUNT, (cols_now == 3 && $urandom_range(0, 1) == 1) ?
                  11'($urandom_range(0, 2)) : 11'(cols_now));
      end
      if (first_phase) begin
        // The receiver holds off for a long stretch in the middle of a dense
        // run of results while cells keep coming with no gaps.
        send_idle = 1'b0;
        stream_cells(40, 50);
        long_hold_asked++;
        stream_cells(200, 50);
        first_phase = 1'b0;
      end else begin
        frame = rows_now * cols_now;
        count = frame * $urandom_range(0, 2) + $urandom_range(1, frame);
        if (count > PHASE_CELLS) count = PHASE_CELLS;
        stream_cells(count, density);
      end
      settle();
    end

    // Closing part: no gaps on either side.
    no_idle = 1'b1;
    write_reg(REG_ROW_COUNT, 11'd6);
    write_reg(REG_COLUMN_COUNT, 11'd7);
    stream_cells(2 * 6 * 7, 40);

    @(negedge clk);
    cells_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lgs_pkg.sv
rtl/core/lgs_cell_if.sv
rtl/core/lgs_result_if.sv
rtl/core/lgs_cfg_if.sv
rtl/core/lgs_scan.sv
rtl/core/lgs_line_mem.sv
rtl/core/lgs_window.sv
rtl/core/life_generation_stencil_top.sv
tb/tb.sv
